FILE: sv/cbq_pkg.sv
`timescale 1ns / 1ps
// cbq_pkg: shared types and constants for the cascaded biquad filter unit
// request/result payload structs, sequencer state, mac control and rounding types
// no dependencies
package cbq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 20;
    localparam int NODE_W     = 24;
    localparam int PROD_W     = COEF_W + NODE_W;
    localparam int ACC_W      = 48;
    localparam int FRAC_SHIFT = 16;
    localparam int SLOTS      = 5;
    localparam int STAGES_W   = 3;
    localparam int CIDX_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W     = 3;

    // request op codes
    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 2'd1;

    // steps of one section on the shared mac
    localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_B0 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_B1 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_B2 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_A1 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MUL_A2 = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ACC_A2 = 3'd6;
    localparam logic [STEP_W-1:0] STEP_ROUND  = 3'd7;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CIDX_W-1:0]         coeff_index;
        logic signed [COEF_W-1:0]  coeff_value;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       clipped;
    } result_t;

    // one delay row: previous and second previous value of a node
    typedef struct packed {
        logic signed [NODE_W-1:0] d1;
        logic signed [NODE_W-1:0] d2;
    } dly_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SECTION,
        ST_TAIL,
        ST_GAIN_MUL,
        ST_GAIN_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [NODE_W-1:0] value;
        logic                     clip;
    } node_rnd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       clip;
    } out_rnd_t;

endpackage

FILE: sv/cascaded_biquad_iir_filter_unit.sv
`timescale 1ns / 1ps
// cascaded_biquad_iir_filter_unit: direct form I biquad cascade, fixed point
// sequencer, coefficient memory and node delay memory around one shared mac
// depends on cbq_pkg and cbq_mac
//
// usage
//   item channel (item_valid/item_ready/item) takes one request at a time:
//   filter a sample, write one coefficient, or clear the node delay line
//   result channel (result_valid/result_ready/result) returns one result for
//   each filter request and none for the others; cfg channel (cfg_valid/
//   cfg_ready/cfg_index/cfg_data) writes active_stages and output_gain and is
//   always ready; the user must write it only while the unit is idle, unchecked
// sequence of a filter request, with n the clamped number of active sections
//   each active section runs the fetch, multiply, accumulate and round steps on
//   the shared mac, then each delay row after the last active section is written
//   (MAX_STAGES + 1 - n rows), then gain multiply, gain accumulate, rounding and
//   output register follow; the next request is taken only once the result is
//   in the output register; coefficient and clear requests are completed when
//   taken and leave the unit idle
// reset clears the coefficients and delay lines through per-entry valid bits
// and sets active_stages to 1 and output_gain to 1.0; no clearing pass is run
// a stalled receiver holds the result in the output register while the next
// request is taken; a finished sample waits in its last step until it drains
module cascaded_biquad_iir_filter_unit
#(
    parameter int MAX_STAGES = 5
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  cbq_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output cbq_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NODES   = MAX_STAGES + 1;
    localparam int NCOEF   = MAX_STAGES * cbq_pkg::SLOTS;
    localparam int COEF_AW = $clog2(NCOEF);
    localparam int STG_W   = $clog2(MAX_STAGES + 1);

    // sequencer state
    cbq_pkg::state_t                  state_reg, state_next;
    logic [cbq_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [STG_W-1:0]                 idx_reg, idx_next;
    logic [COEF_AW-1:0]               base_reg, base_next;
    logic                             clip_reg, clip_next;

    // working node values: x is the section input, x1/x2 its history,
    // y1/y2 the history of the section output
    logic signed [cbq_pkg::NODE_W-1:0] x_reg, x_next;
    logic signed [cbq_pkg::NODE_W-1:0] x1_reg, x1_next;
    logic signed [cbq_pkg::NODE_W-1:0] x2_reg, x2_next;
    logic signed [cbq_pkg::NODE_W-1:0] y1_reg, y1_next;
    logic signed [cbq_pkg::NODE_W-1:0] y2_reg, y2_next;

    // configuration registers
    logic [cbq_pkg::STAGES_W-1:0]      active_stages_reg;
    logic signed [cbq_pkg::COEF_W-1:0] output_gain_reg;
    logic [STG_W-1:0]                  n_eff;
    logic [STG_W-1:0]                  last_sec;

    // coefficient memory with per-entry valid bits
    logic signed [cbq_pkg::COEF_W-1:0] coef_mem [NCOEF];
    logic                              coef_vld_reg [NCOEF];
    logic signed [cbq_pkg::COEF_W-1:0] coef_rd_reg;
    logic                              coef_rd_vld_reg;
    logic signed [cbq_pkg::COEF_W-1:0] coef_rdata;
    logic                              coef_we;
    logic [COEF_AW-1:0]                coef_waddr;
    logic                              coef_rd_en;
    logic [COEF_AW-1:0]                coef_raddr;

    // node delay memory, one row per node, with per-row valid bits
    cbq_pkg::dly_row_t                 dly_mem [NODES];
    logic                              dly_vld_reg [NODES];
    cbq_pkg::dly_row_t                 dly_rd_reg;
    logic                              dly_rd_vld_reg;
    cbq_pkg::dly_row_t                 dly_rdata;
    logic                              dly_rd_en;
    logic [STG_W-1:0]                  dly_raddr;
    logic                              dly_we;
    logic [STG_W-1:0]                  dly_waddr;
    cbq_pkg::dly_row_t                 dly_wdata;

    // shared mac
    cbq_pkg::mac_ctrl_t                mac_ctrl;
    logic signed [cbq_pkg::COEF_W-1:0] mac_coef;
    logic signed [cbq_pkg::NODE_W-1:0] mac_node;
    cbq_pkg::node_rnd_t                node_rnd;
    cbq_pkg::out_rnd_t                 out_rnd;

    // output register
    cbq_pkg::result_t                  result_reg;
    logic                              result_valid_reg;
    logic                              result_load;

    logic                              item_accept;
    logic                              clear_accept;

    assign item_ready   = (state_reg == cbq_pkg::ST_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign clear_accept = item_accept && (item.op == cbq_pkg::OP_CLEAR);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_stages_reg <= 3'd1;
            output_gain_reg   <= 20'sd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbq_pkg::CFG_ACTIVE_STAGES:
                    active_stages_reg <= cfg_data[cbq_pkg::STAGES_W-1:0];
                cbq_pkg::CFG_OUTPUT_GAIN:
                    output_gain_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // stage count clamped to 1..MAX_STAGES
    always_comb
    begin
        if (active_stages_reg == '0)
        begin
            n_eff = STG_W'(1);
        end
        else if (int'(active_stages_reg) > MAX_STAGES)
        begin
            n_eff = STG_W'(MAX_STAGES);
        end
        else
        begin
            n_eff = STG_W'(active_stages_reg);
        end
    end

    assign last_sec = n_eff - STG_W'(1);

    // coefficient write path, out-of-range indexes are dropped
    assign coef_we    = item_accept && (item.op == cbq_pkg::OP_COEF)
                        && (int'(item.coeff_index) < NCOEF);
    assign coef_waddr = COEF_AW'(item.coeff_index);

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= item.coeff_value;
        end
        if (coef_rd_en)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_vld_reg[i] <= 1'b0;
            end
            coef_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (coef_rd_en)
            begin
                coef_rd_vld_reg <= coef_vld_reg[coef_raddr];
            end
        end
    end

    assign coef_rdata = coef_rd_vld_reg ? coef_rd_reg : '0;

    // node delay memory
    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[dly_waddr] <= dly_wdata;
        end
        if (dly_rd_en)
        begin
            dly_rd_reg <= dly_mem[dly_raddr];
        end
    end

    // clear request drops every row back to zero through its valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                dly_vld_reg[i] <= 1'b0;
            end
            dly_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear_accept)
            begin
                for (int i = 0; i < NODES; i++)
                begin
                    dly_vld_reg[i] <= 1'b0;
                end
            end
            else if (dly_we)
            begin
                dly_vld_reg[dly_waddr] <= 1'b1;
            end
            if (dly_rd_en)
            begin
                dly_rd_vld_reg <= dly_vld_reg[dly_raddr];
            end
        end
    end

    assign dly_rdata = dly_rd_vld_reg ? dly_rd_reg : '0;

    cbq_mac u_mac
    (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .coef     (mac_coef),
        .node     (mac_node),
        .node_rnd (node_rnd),
        .out_rnd  (out_rnd)
    );

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbq_pkg::ST_IDLE;
            step_reg  <= cbq_pkg::STEP_FETCH;
            idx_reg   <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        y1_reg   <= y1_next;
        y2_reg   <= y2_next;
        clip_reg <= clip_next;
    end

    // sequencer: sections on the shared mac, then delay rows, then gain
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        base_next   = base_reg;
        x_next      = x_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        y1_next     = y1_reg;
        y2_next     = y2_reg;
        clip_next   = clip_reg;
        coef_rd_en  = 1'b0;
        coef_raddr  = base_reg + COEF_AW'(step_reg);
        dly_rd_en   = 1'b0;
        dly_raddr   = idx_reg + STG_W'(1);
        dly_we      = 1'b0;
        dly_waddr   = idx_reg;
        dly_wdata   = '0;
        mac_ctrl    = '{mul_en: 1'b0, acc_op: cbq_pkg::ACC_HOLD};
        mac_coef    = coef_rdata;
        mac_node    = x_reg;
        result_load = 1'b0;

        unique case (state_reg)
            cbq_pkg::ST_IDLE:
            begin
                // keep row 0 in the read register for the first section
                dly_rd_en = 1'b1;
                dly_raddr = '0;
                if (item_accept && (item.op == cbq_pkg::OP_FILTER))
                begin
                    state_next = cbq_pkg::ST_SECTION;
                    step_next  = cbq_pkg::STEP_FETCH;
                    idx_next   = '0;
                    base_next  = '0;
                    x_next     = {{(cbq_pkg::NODE_W - cbq_pkg::SAMPLE_W)
                                   {item.sample[cbq_pkg::SAMPLE_W-1]}}, item.sample};
                    clip_next  = 1'b0;
                end
            end

            cbq_pkg::ST_SECTION:
            begin
                step_next = step_reg + cbq_pkg::STEP_W'(1);
                case (step_reg)
                    cbq_pkg::STEP_FETCH:
                    begin
                        coef_rd_en = 1'b1;
                        dly_rd_en  = 1'b1;
                        if (idx_reg == '0)
                        begin
                            x1_next = dly_rdata.d1;
                            x2_next = dly_rdata.d2;
                        end
                    end
                    cbq_pkg::STEP_MUL_B0:
                    begin
                        coef_rd_en      = 1'b1;
                        mac_ctrl.mul_en = 1'b1;
                        mac_node        = x_reg;
                        y1_next         = dly_rdata.d1;
                        y2_next         = dly_rdata.d2;
                    end
                    cbq_pkg::STEP_MUL_B1:
                    begin
                        coef_rd_en      = 1'b1;
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.acc_op = cbq_pkg::ACC_LOAD;
                        mac_node        = x1_reg;
                    end
                    cbq_pkg::STEP_MUL_B2:
                    begin
                        coef_rd_en      = 1'b1;
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.acc_op = cbq_pkg::ACC_ADD;
                        mac_node        = x2_reg;
                    end
                    cbq_pkg::STEP_MUL_A1:
                    begin
                        coef_rd_en      = 1'b1;
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.acc_op = cbq_pkg::ACC_ADD;
                        mac_node        = y1_reg;
                    end
                    cbq_pkg::STEP_MUL_A2:
                    begin
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.acc_op = cbq_pkg::ACC_SUB;
                        mac_node        = y2_reg;
                    end
                    cbq_pkg::STEP_ACC_A2:
                    begin
                        mac_ctrl.acc_op = cbq_pkg::ACC_SUB;
                    end
                    cbq_pkg::STEP_ROUND:
                    begin
                        // shift the input node's history, section output
                        // becomes the next section's input
                        dly_we    = 1'b1;
                        dly_wdata = '{d1: x_reg, d2: x1_reg};
                        x_next    = node_rnd.value;
                        x1_next   = y1_reg;
                        x2_next   = y2_reg;
                        clip_next = clip_reg | node_rnd.clip;
                        idx_next  = idx_reg + STG_W'(1);
                        base_next = base_reg + COEF_AW'(cbq_pkg::SLOTS);
                        step_next = cbq_pkg::STEP_FETCH;
                        if (idx_reg == last_sec)
                        begin
                            state_next = cbq_pkg::ST_TAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            cbq_pkg::ST_TAIL:
            begin
                // last active node takes its value, inactive nodes shift in zero
                dly_we = 1'b1;
                if (idx_reg == n_eff)
                begin
                    dly_wdata = '{d1: x_reg, d2: x1_reg};
                end
                else
                begin
                    dly_wdata = '{d1: '0, d2: dly_rdata.d1};
                end
                if (idx_reg == STG_W'(MAX_STAGES))
                begin
                    state_next = cbq_pkg::ST_GAIN_MUL;
                end
                else
                begin
                    dly_rd_en = 1'b1;
                    idx_next  = idx_reg + STG_W'(1);
                end
            end

            cbq_pkg::ST_GAIN_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = output_gain_reg;
                mac_node        = x_reg;
                state_next      = cbq_pkg::ST_GAIN_ACC;
            end

            cbq_pkg::ST_GAIN_ACC:
            begin
                mac_ctrl.acc_op = cbq_pkg::ACC_LOAD;
                state_next      = cbq_pkg::ST_DONE;
            end

            cbq_pkg::ST_DONE:
            begin
                // wait here only while the output register is still full
                if (!result_valid_reg || result_ready)
                begin
                    result_load = 1'b1;
                    state_next  = cbq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cbq_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.filtered <= out_rnd.value;
            result_reg.clipped  <= clip_reg | out_rnd.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: sv/cbq_mac.sv
`timescale 1ns / 1ps
// cbq_mac: shared multiply-accumulate unit with round-half-up and saturation
// one registered 20x24 product feeding a 48-bit accumulator
// depends on cbq_pkg
module cbq_mac
(
    input  logic                                 clk,
    input  cbq_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [cbq_pkg::COEF_W-1:0]    coef,
    input  logic signed [cbq_pkg::NODE_W-1:0]    node,
    output cbq_pkg::node_rnd_t                   node_rnd,
    output cbq_pkg::out_rnd_t                    out_rnd
);

    localparam int SH_W = cbq_pkg::ACC_W - cbq_pkg::FRAC_SHIFT;

    localparam logic signed [cbq_pkg::ACC_W-1:0] RND_HALF = 48'sd32768;
    localparam logic signed [SH_W-1:0] NODE_HI = 32'sd8388607;
    localparam logic signed [SH_W-1:0] NODE_LO = -32'sd8388608;
    localparam logic signed [SH_W-1:0] OUT_HI  = 32'sd32767;
    localparam logic signed [SH_W-1:0] OUT_LO  = -32'sd32768;

    logic signed [cbq_pkg::PROD_W-1:0] prod_reg;
    logic signed [cbq_pkg::ACC_W-1:0]  acc_reg;
    logic signed [cbq_pkg::ACC_W-1:0]  prod_ext;
    logic signed [cbq_pkg::ACC_W-1:0]  biased;
    logic signed [SH_W-1:0]            shifted;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * node;
        end
    end

    assign prod_ext = {{(cbq_pkg::ACC_W - cbq_pkg::PROD_W){prod_reg[cbq_pkg::PROD_W-1]}},
                       prod_reg};

    always_ff @(posedge clk)
    begin
        case (ctrl.acc_op)
            cbq_pkg::ACC_LOAD: acc_reg <= prod_ext;
            cbq_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            cbq_pkg::ACC_SUB:  acc_reg <= acc_reg - prod_ext;
            default:           acc_reg <= acc_reg;
        endcase
    end

    // floor of (acc + half) / 2^16 is the upper part of the biased sum
    assign biased  = acc_reg + RND_HALF;
    assign shifted = biased[cbq_pkg::ACC_W-1:cbq_pkg::FRAC_SHIFT];

    always_comb
    begin
        if (shifted > NODE_HI)
        begin
            node_rnd.value = NODE_HI[cbq_pkg::NODE_W-1:0];
            node_rnd.clip  = 1'b1;
        end
        else if (shifted < NODE_LO)
        begin
            node_rnd.value = NODE_LO[cbq_pkg::NODE_W-1:0];
            node_rnd.clip  = 1'b1;
        end
        else
        begin
            node_rnd.value = shifted[cbq_pkg::NODE_W-1:0];
            node_rnd.clip  = 1'b0;
        end
    end

    always_comb
    begin
        if (shifted > OUT_HI)
        begin
            out_rnd.value = OUT_HI[cbq_pkg::SAMPLE_W-1:0];
            out_rnd.clip  = 1'b1;
        end
        else if (shifted < OUT_LO)
        begin
            out_rnd.value = OUT_LO[cbq_pkg::SAMPLE_W-1:0];
            out_rnd.clip  = 1'b1;
        end
        else
        begin
            out_rnd.value = shifted[cbq_pkg::SAMPLE_W-1:0];
            out_rnd.clip  = 1'b0;
        end
    end

endmodule
